@@ sv/mmg_pkg.sv @@
// shared types and constants of the matrix multiply with gradients block
package mmg_pkg;

  localparam int MAX_DIM     = 64;
  localparam int DIM_W       = $clog2(MAX_DIM);
  localparam int LEN_W       = DIM_W + 1;
  localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
  localparam int ADDR_W      = 2 * DIM_W;
  localparam int DATA_W      = 16;
  localparam int FRAC_BITS   = 12;
  localparam int PROD_W      = 2 * DATA_W;
  localparam int ACC_W       = 48;
  localparam int CFG_W       = 7;
  localparam int CFG_IDX_W   = 2;
  localparam int OP_W        = 3;
  localparam int STATUS_W    = 2;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE_A = 3'd0,
    OP_WRITE_B = 3'd1,
    OP_WRITE_G = 3'd2,
    OP_FORWARD = 3'd3,
    OP_GRAD_A  = 3'd4,
    OP_GRAD_B  = 3'd5
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_SAT   = 2'd1,
    STATUS_RANGE = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROWS_A     = 2'd0,
    CFG_INNER_SIZE = 2'd1,
    CFG_COLS_B     = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_ERR
  } state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic write;   // store the element of the accepted write beat
    logic load;    // latch the compute beat, clear walk and accumulator
    logic issue;   // read one operand pair and step the walk
    logic finish;  // round, saturate and present the result
    logic error;   // present an out-of-range result
  } mmg_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic is_write;
    logic is_compute;
    logic range_ok;
    logic empty;   // walk of the incoming compute beat has zero length
    logic last;
    logic pipe_busy;
  } mmg_stat_t;

endpackage

@@ sv/mmg_ctrl.sv @@
// controller state machine of the matrix multiply with gradients block
module mmg_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  mmg_pkg::mmg_stat_t stat_i,
  output mmg_pkg::mmg_cmd_t  cmd_o
);

  mmg_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mmg_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      mmg_pkg::ST_IDLE: begin
        if (start && stat_i.is_compute) begin
          state_d = !stat_i.range_ok ? mmg_pkg::ST_ERR   :
                    stat_i.empty     ? mmg_pkg::ST_DRAIN : mmg_pkg::ST_WALK;
        end
      end
      mmg_pkg::ST_WALK: begin
        if (stat_i.last) begin
          state_d = mmg_pkg::ST_DRAIN;
        end
      end
      mmg_pkg::ST_DRAIN: begin
        if (!stat_i.pipe_busy) begin
          state_d = mmg_pkg::ST_IDLE;
        end
      end
      mmg_pkg::ST_ERR: begin
        state_d = mmg_pkg::ST_IDLE;
      end
      default: begin
        state_d = mmg_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    cmd_o = '0;
    busy  = 1'b1;
    case (state_q)
      mmg_pkg::ST_IDLE: begin
        busy         = 1'b0;
        cmd_o.write  = start && stat_i.is_write;
        cmd_o.load   = start && stat_i.is_compute;
      end
      mmg_pkg::ST_WALK: begin
        cmd_o.issue = 1'b1;
      end
      mmg_pkg::ST_DRAIN: begin
        cmd_o.finish = !stat_i.pipe_busy;
      end
      mmg_pkg::ST_ERR: begin
        cmd_o.error = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

@@ sv/mmg_datapath.sv @@
// element stores, size registers, multiply-accumulate and result rounding
module mmg_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [mmg_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [mmg_pkg::CFG_W-1:0]           cfg_data_i,
  input  logic [mmg_pkg::OP_W-1:0]            op_i,
  input  logic [mmg_pkg::DIM_W-1:0]           row_index_i,
  input  logic [mmg_pkg::DIM_W-1:0]           col_index_i,
  input  logic signed [mmg_pkg::DATA_W-1:0]   element_value_i,
  input  mmg_pkg::mmg_cmd_t                   cmd_i,
  output mmg_pkg::mmg_stat_t                  stat_o,
  output logic signed [mmg_pkg::DATA_W-1:0]   result_value_o,
  output logic [mmg_pkg::STATUS_W-1:0]        status_o,
  output logic                                result_valid_o
);

  localparam int SumW = mmg_pkg::ACC_W + 1;
  localparam logic [mmg_pkg::LEN_W-1:0] DimMax = mmg_pkg::LEN_W'(mmg_pkg::MAX_DIM);
  localparam logic [mmg_pkg::LEN_W-1:0] LenOne = mmg_pkg::LEN_W'(1);
  localparam logic signed [SumW-1:0] RoundBias =
    (mmg_pkg::FRAC_BITS > 0) ? SumW'(1) <<< (mmg_pkg::FRAC_BITS - 1) : '0;
  localparam logic signed [SumW-1:0] MaxVal = SumW'((2 ** (mmg_pkg::DATA_W - 1)) - 1);
  localparam logic signed [SumW-1:0] MinVal = -MaxVal - SumW'(1);

  // size registers
  logic [mmg_pkg::CFG_W-1:0] rows_a_q, inner_size_q, cols_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_a_q     <= mmg_pkg::CFG_W'(mmg_pkg::MAX_DIM);
      inner_size_q <= mmg_pkg::CFG_W'(mmg_pkg::MAX_DIM);
      cols_b_q     <= mmg_pkg::CFG_W'(mmg_pkg::MAX_DIM);
    end else if (cfg_we_i) begin
      case (mmg_pkg::cfg_idx_e'(cfg_index_i))
        mmg_pkg::CFG_ROWS_A:     rows_a_q     <= cfg_data_i;
        mmg_pkg::CFG_INNER_SIZE: inner_size_q <= cfg_data_i;
        mmg_pkg::CFG_COLS_B:     cols_b_q     <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  logic [mmg_pkg::LEN_W-1:0] dim_m, dim_k, dim_n;
  assign dim_m = (rows_a_q     > DimMax) ? DimMax : rows_a_q;
  assign dim_k = (inner_size_q > DimMax) ? DimMax : inner_size_q;
  assign dim_n = (cols_b_q     > DimMax) ? DimMax : cols_b_q;

  // decode of the incoming beat
  logic [mmg_pkg::LEN_W-1:0] row_ext, col_ext, walk_len;
  logic                      range_ok;
  logic                      is_write, is_compute;

  assign row_ext = {1'b0, row_index_i};
  assign col_ext = {1'b0, col_index_i};

  always_comb begin
    is_write   = 1'b0;
    is_compute = 1'b1;
    range_ok   = 1'b0;
    walk_len   = dim_k;
    case (mmg_pkg::op_e'(op_i))
      mmg_pkg::OP_WRITE_A, mmg_pkg::OP_WRITE_B, mmg_pkg::OP_WRITE_G: begin
        is_write   = 1'b1;
        is_compute = 1'b0;
      end
      mmg_pkg::OP_FORWARD: begin
        range_ok = (row_ext < dim_m) && (col_ext < dim_n);
        walk_len = dim_k;
      end
      mmg_pkg::OP_GRAD_A: begin
        range_ok = (row_ext < dim_m) && (col_ext < dim_k);
        walk_len = dim_n;
      end
      mmg_pkg::OP_GRAD_B: begin
        range_ok = (row_ext < dim_k) && (col_ext < dim_n);
        walk_len = dim_m;
      end
      default: begin
        is_compute = 1'b0;
      end
    endcase
  end

  // latched compute beat and walk counter
  mmg_pkg::op_e              op_q;
  logic [mmg_pkg::DIM_W-1:0] row_q, col_q;
  logic [mmg_pkg::LEN_W-1:0] len_q, t_q;
  logic [mmg_pkg::DIM_W-1:0] t_idx;

  assign t_idx = t_q[mmg_pkg::DIM_W-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= mmg_pkg::op_e'(op_i);
      row_q <= row_index_i;
      col_q <= col_index_i;
      len_q <= walk_len;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t_q <= '0;
    end else if (cmd_i.load) begin
      t_q <= '0;
    end else if (cmd_i.issue) begin
      t_q <= t_q + LenOne;
    end
  end

  // read addresses per mode
  logic [mmg_pkg::ADDR_W-1:0] a_raddr, b_raddr, g_raddr, waddr;

  assign waddr   = {row_index_i, col_index_i};
  assign a_raddr = (op_q == mmg_pkg::OP_GRAD_B)  ? {t_idx, row_q} : {row_q, t_idx};
  assign b_raddr = (op_q == mmg_pkg::OP_GRAD_A)  ? {col_q, t_idx} : {t_idx, col_q};
  assign g_raddr = (op_q == mmg_pkg::OP_GRAD_A)  ? {row_q, t_idx} : {t_idx, col_q};

  // element stores
  logic [mmg_pkg::DATA_W-1:0] a_mem [mmg_pkg::STORE_DEPTH];
  logic [mmg_pkg::DATA_W-1:0] b_mem [mmg_pkg::STORE_DEPTH];
  logic [mmg_pkg::DATA_W-1:0] g_mem [mmg_pkg::STORE_DEPTH];
  logic [mmg_pkg::DATA_W-1:0] a_rd_q, b_rd_q, g_rd_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.write && (mmg_pkg::op_e'(op_i) == mmg_pkg::OP_WRITE_A)) begin
      a_mem[waddr] <= element_value_i;
    end
    if (cmd_i.issue) begin
      a_rd_q <= a_mem[a_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.write && (mmg_pkg::op_e'(op_i) == mmg_pkg::OP_WRITE_B)) begin
      b_mem[waddr] <= element_value_i;
    end
    if (cmd_i.issue) begin
      b_rd_q <= b_mem[b_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.write && (mmg_pkg::op_e'(op_i) == mmg_pkg::OP_WRITE_G)) begin
      g_mem[waddr] <= element_value_i;
    end
    if (cmd_i.issue) begin
      g_rd_q <= g_mem[g_raddr];
    end
  end

  // multiply-accumulate pipeline
  logic                              rd_vld_q, prod_vld_q;
  logic signed [mmg_pkg::DATA_W-1:0] x_op, y_op;
  logic signed [mmg_pkg::PROD_W-1:0] prod_q;
  logic signed [mmg_pkg::ACC_W-1:0]  acc_q;

  assign x_op = (op_q == mmg_pkg::OP_GRAD_A) ? g_rd_q : a_rd_q;
  assign y_op = (op_q == mmg_pkg::OP_GRAD_B) ? g_rd_q : b_rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q   <= 1'b0;
      prod_vld_q <= 1'b0;
    end else begin
      rd_vld_q   <= cmd_i.issue;
      prod_vld_q <= rd_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_vld_q) begin
      prod_q <= x_op * y_op;
    end
    if (cmd_i.load) begin
      acc_q <= '0;
    end else if (prod_vld_q) begin
      acc_q <= acc_q + mmg_pkg::ACC_W'(prod_q);
    end
  end

  // round half up, drop fraction, saturate
  logic signed [SumW-1:0] sum_rnd, sum_shift;
  logic                   sat_hi, sat_lo;

  assign sum_rnd   = {acc_q[mmg_pkg::ACC_W-1], acc_q} + RoundBias;
  assign sum_shift = sum_rnd >>> mmg_pkg::FRAC_BITS;
  assign sat_hi    = sum_shift > MaxVal;
  assign sat_lo    = sum_shift < MinVal;

  logic signed [mmg_pkg::DATA_W-1:0] result_q;
  logic [mmg_pkg::STATUS_W-1:0]      status_q;
  logic                              valid_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.error) begin
      result_q <= '0;
      status_q <= mmg_pkg::STATUS_RANGE;
    end else if (cmd_i.finish) begin
      if (sat_hi) begin
        result_q <= MaxVal[mmg_pkg::DATA_W-1:0];
        status_q <= mmg_pkg::STATUS_SAT;
      end else if (sat_lo) begin
        result_q <= MinVal[mmg_pkg::DATA_W-1:0];
        status_q <= mmg_pkg::STATUS_SAT;
      end else begin
        result_q <= sum_shift[mmg_pkg::DATA_W-1:0];
        status_q <= mmg_pkg::STATUS_OK;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.error || cmd_i.finish;
    end
  end

  assign result_value_o = result_q;
  assign status_o       = status_q;
  assign result_valid_o = valid_q;

  assign stat_o.is_write   = is_write;
  assign stat_o.is_compute = is_compute;
  assign stat_o.range_ok   = range_ok;
  assign stat_o.empty      = (walk_len == '0);
  assign stat_o.last       = (t_q == (len_q - LenOne));
  assign stat_o.pipe_busy  = rd_vld_q || prod_vld_q;

endmodule

@@ sv/matrix_multiply_with_gradients.sv @@
// top level of the matrix multiply with gradients block
// A beat is taken at a rising edge with start high and busy low. Write beats
// (op 0..2) store one element while busy stays low. A compute beat (op 3..5)
// walks its inner product through a single 16x16 multiply-accumulate, one
// element pair per cycle read from the element stores: busy is high through
// the walk and the drain of the multiply pipeline, the walked size being k for
// forward, n for gradient of A and m for gradient of B, and result_valid_o
// pulses for one cycle once the pipeline has drained. A walked size of zero
// skips the walk and gives a zero result with status 0. An index outside the
// configured sizes skips the walk and its result pulses with status 2.
// The result pulse cannot be held off: the receiver must take it in that
// cycle. A new beat may be issued in the same cycle as the pulse. Op codes
// 6 and 7 are dropped without a result. The user writes the size registers
// through cfg_we_i/cfg_index_i/cfg_data_i only while idle (the block does not
// enforce it); stores have no reset and must be loaded before they are read.
module matrix_multiply_with_gradients (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration
  input  logic                                cfg_we_i,
  input  logic [mmg_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [mmg_pkg::CFG_W-1:0]           cfg_data_i,
  // command beat
  input  logic                                start,
  output logic                                busy,
  input  logic [mmg_pkg::OP_W-1:0]            op_i,
  input  logic [mmg_pkg::DIM_W-1:0]           row_index_i,
  input  logic [mmg_pkg::DIM_W-1:0]           col_index_i,
  input  logic signed [mmg_pkg::DATA_W-1:0]   element_value_i,
  // result beat
  output logic                                result_valid_o,
  output logic signed [mmg_pkg::DATA_W-1:0]   result_value_o,
  output logic [mmg_pkg::STATUS_W-1:0]        status_o
);

  mmg_pkg::mmg_cmd_t  cmd;
  mmg_pkg::mmg_stat_t stat;

  // sequencing of write, walk, drain and result
  mmg_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  // stores, size registers, mac and output registers
  mmg_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .op_i            (op_i),
    .row_index_i     (row_index_i),
    .col_index_i     (col_index_i),
    .element_value_i (element_value_i),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .result_value_o  (result_value_o),
    .status_o        (status_o),
    .result_valid_o  (result_valid_o)
  );

endmodule

@@ tb/matrix_multiply_with_gradients_tb.sv @@
`timescale 1ns / 1ps
// self-checking testbench of the matrix multiply with gradients block
module matrix_multiply_with_gradients_tb;

  localparam int HALF_PERIOD  = 4;
  localparam int RESET_CYCLES = 12;
  localparam int GAP_PCT      = 14;
  localparam int SHOW_MAX     = 10;
  localparam int STALL_LIMIT  = 2000;
  localparam int SETTLE       = 8;
  localparam int PHASE_BEATS  = 90;
  localparam int SMALL_DIM    = 16;
  localparam int N_FIXED      = 13;
  localparam int N_RANDOM     = 5;
  localparam int CALM_PHASE   = 3;
  localparam int DIM_W        = mmg_pkg::DIM_W;
  localparam int DATA_W       = mmg_pkg::DATA_W;
  localparam int OP_W         = mmg_pkg::OP_W;
  localparam int CFG_W        = mmg_pkg::CFG_W;
  localparam int MAX_DIM      = mmg_pkg::MAX_DIM;
  localparam int STORE_DEPTH  = mmg_pkg::STORE_DEPTH;
  localparam int ONE_Q        = 1 << mmg_pkg::FRAC_BITS;
  localparam longint SAT_HI   = (longint'(1) <<< (DATA_W - 1)) - 1;
  localparam longint SAT_LO   = -SAT_HI - 1;
  // op codes the block drops without a result
  localparam logic [OP_W-1:0] OP_RSVD_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD_HI = 3'd7;

  typedef struct packed {
    logic [OP_W-1:0]          op;
    logic [DIM_W-1:0]         row;
    logic [DIM_W-1:0]         col;
    logic signed [DATA_W-1:0] value;
    logic                     may_gap;  // sender may idle before this beat
  } beat_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    mmg_pkg::status_e         status;
  } elem_result_t;

  // sizes (m, k, n) of the fixed phases: small, lopsided, zero, clamped, full
  int fixed_dims [N_FIXED][3] = '{
    '{4, 4, 4}, '{3, 7, 5}, '{8, 2, 6}, '{16, 16, 16}, '{1, 64, 1}, '{64, 1, 64},
    '{0, 5, 3}, '{5, 0, 4}, '{6, 4, 0}, '{127, 3, 2}, '{2, 127, 127},
    '{64, 64, 64}, '{65, 9, 100}};

  logic                            clk_i           = 1'b0;
  logic                            rst_ni          = 1'b0;
  logic                            cfg_we_i        = 1'b0;
  logic [mmg_pkg::CFG_IDX_W-1:0]   cfg_index_i     = mmg_pkg::CFG_ROWS_A;
  logic [CFG_W-1:0]                cfg_data_i      = '0;
  logic                            start           = 1'b0;
  logic                            busy;
  logic [OP_W-1:0]                 op_i            = mmg_pkg::OP_WRITE_A;
  logic [DIM_W-1:0]                row_index_i     = '0;
  logic [DIM_W-1:0]                col_index_i     = '0;
  logic signed [DATA_W-1:0]        element_value_i = '0;
  logic                            result_valid_o;
  logic signed [DATA_W-1:0]        result_value_o;
  logic [mmg_pkg::STATUS_W-1:0]    status_o;

  matrix_multiply_with_gradients u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .start           (start),
    .busy            (busy),
    .op_i            (op_i),
    .row_index_i     (row_index_i),
    .col_index_i     (col_index_i),
    .element_value_i (element_value_i),
    .result_valid_o  (result_valid_o),
    .result_value_o  (result_value_o),
    .status_o        (status_o)
  );

  // 8 ns clock
  always begin
    #HALF_PERIOD clk_i = 1'b1;
    #HALF_PERIOD clk_i = 1'b0;
  end

  // beats waiting for the driver, and the beat now on the ports
  beat_t        pending_beats [$];
  beat_t        on_port;
  // results predicted for accepted compute beats, oldest first
  elem_result_t expected_elems [$];

  // predictor copy of the element stores and the size registers
  logic signed [DATA_W-1:0] a_copy [STORE_DEPTH];
  logic signed [DATA_W-1:0] b_copy [STORE_DEPTH];
  logic signed [DATA_W-1:0] g_copy [STORE_DEPTH];
  logic [CFG_W-1:0]         rows_cfg  = CFG_W'(MAX_DIM);
  logic [CFG_W-1:0]         inner_cfg = CFG_W'(MAX_DIM);
  logic [CFG_W-1:0]         cols_cfg  = CFG_W'(MAX_DIM);

  // which store entries the stimulus has loaded, indexed by write op
  bit written [3][STORE_DEPTH];
  int planned      = 0;
  int mismatch_cnt = 0;
  int stall_cycles = 0;

  // sizes above the store dimension act as the store dimension
  function automatic int dim_limit(logic [CFG_W-1:0] d);
    return (d > MAX_DIM) ? MAX_DIM : int'(d);
  endfunction

  // one output element: range check, inner-product walk, round half up, saturate
  function automatic elem_result_t inner_product(beat_t b);
    elem_result_t r;
    int m, k, n, len, t;
    bit in_range;
    logic signed [mmg_pkg::ACC_W-1:0] acc;
    longint x, y, sum;
    m = dim_limit(rows_cfg);
    k = dim_limit(inner_cfg);
    n = dim_limit(cols_cfg);
    case (b.op)
      mmg_pkg::OP_FORWARD: begin
        in_range = b.row < m && b.col < n;
        len = k;
      end
      mmg_pkg::OP_GRAD_A: begin
        in_range = b.row < m && b.col < k;
        len = n;
      end
      default: begin
        in_range = b.row < k && b.col < n;
        len = m;
      end
    endcase
    r.value  = '0;
    r.status = mmg_pkg::STATUS_RANGE;
    if (!in_range) return r;
    acc = '0;
    for (t = 0; t < len; t++) begin
      case (b.op)
        mmg_pkg::OP_FORWARD: begin
          x = a_copy[{b.row, DIM_W'(t)}];
          y = b_copy[{DIM_W'(t), b.col}];
        end
        mmg_pkg::OP_GRAD_A: begin  // G times B transposed
          x = g_copy[{b.row, DIM_W'(t)}];
          y = b_copy[{b.col, DIM_W'(t)}];
        end
        default: begin             // A transposed times G
          x = a_copy[{DIM_W'(t), b.row}];
          y = g_copy[{DIM_W'(t), b.col}];
        end
      endcase
      acc = acc + mmg_pkg::ACC_W'(x * y);
    end
    sum = acc;
    sum = (sum + (longint'(1) <<< (mmg_pkg::FRAC_BITS - 1))) >>> mmg_pkg::FRAC_BITS;
    if (sum > SAT_HI) begin
      r.value  = DATA_W'(SAT_HI);
      r.status = mmg_pkg::STATUS_SAT;
    end else if (sum < SAT_LO) begin
      r.value  = DATA_W'(SAT_LO);
      r.status = mmg_pkg::STATUS_SAT;
    end else begin
      r.value  = sum[DATA_W-1:0];
      r.status = mmg_pkg::STATUS_OK;
    end
    return r;
  endfunction

  // element values: full range, around one, near zero, or an extreme
  function automatic logic signed [DATA_W-1:0] rand_elem();
    case ($urandom_range(3))
      0:       return DATA_W'($urandom);
      1:       return DATA_W'(int'($urandom_range(2 * ONE_Q)) - ONE_Q);
      2:       return DATA_W'(int'($urandom_range(512)) - 256);
      default: return $urandom_range(1) ? DATA_W'(SAT_HI) : DATA_W'(SAT_LO);
    endcase
  endfunction

  function automatic void add_beat(logic [OP_W-1:0] op, logic [DIM_W-1:0] row,
                                   logic [DIM_W-1:0] col,
                                   logic signed [DATA_W-1:0] value, bit gap);
    pending_beats.push_back('{op, row, col, value, gap});
    if (op <= mmg_pkg::OP_WRITE_G) written[op][{row, col}] = 1'b1;
    // dropped op codes do not count toward the phase length
    if (op <= mmg_pkg::OP_GRAD_B) planned++;
  endfunction

  // load a store entry that a coming walk reads, unless already loaded
  function automatic void touch(logic [OP_W-1:0] op, int row, int col, bit gap);
    if (!written[op][{DIM_W'(row), DIM_W'(col)}])
      add_beat(op, DIM_W'(row), DIM_W'(col), rand_elem(), gap);
  endfunction

  // mostly in range; small sizes anywhere, large sizes only at the edges
  function automatic logic [DIM_W-1:0] pick_index(int lim);
    if (lim == 0 || (lim < MAX_DIM && $urandom_range(9) == 0))
      return DIM_W'($urandom_range(MAX_DIM - 1, lim));
    if (lim <= SMALL_DIM) return DIM_W'($urandom_range(lim - 1));
    case ($urandom_range(2))
      0:       return '0;
      1:       return DIM_W'(1);
      default: return DIM_W'(lim - 1);
    endcase
  endfunction

  function automatic bit block_active();
    return pending_beats.size() != 0 || start || busy || expected_elems.size() != 0;
  endfunction

  // all beats taken, all results in, plus a settling wait for trailing writes
  task automatic wait_idle();
    do begin
      while (block_active()) @(posedge clk_i);
      repeat (SETTLE) @(posedge clk_i);
    end while (block_active());
  endtask

  // size registers are only written with the block idle
  task automatic set_sizes(int m, int k, int n);
    wait_idle();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= mmg_pkg::CFG_ROWS_A;
    cfg_data_i  <= CFG_W'(m);
    @(posedge clk_i);
    cfg_index_i <= mmg_pkg::CFG_INNER_SIZE;
    cfg_data_i  <= CFG_W'(k);
    @(posedge clk_i);
    cfg_index_i <= mmg_pkg::CFG_COLS_B;
    cfg_data_i  <= CFG_W'(n);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    rows_cfg  = CFG_W'(m);
    inner_cfg = CFG_W'(k);
    cols_cfg  = CFG_W'(n);
  endtask

  // random beats at one setting of the sizes
  task automatic random_phase(int m, int k, int n, bit gap);
    int stop, roll, rl, cl, len, t, lim_m, lim_k, lim_n;
    logic [OP_W-1:0] op;
    logic [DIM_W-1:0] row, col;
    set_sizes(m, k, n);
    lim_m = dim_limit(rows_cfg);
    lim_k = dim_limit(inner_cfg);
    lim_n = dim_limit(cols_cfg);
    stop  = planned + PHASE_BEATS;
    while (planned < stop) begin
      roll = $urandom_range(99);
      if (roll < 3) begin
        // noise: dropped op codes with random fields
        add_beat($urandom_range(1) ? OP_RSVD_LO : OP_RSVD_HI,
                 DIM_W'($urandom), DIM_W'($urandom), DATA_W'($urandom), gap);
      end else if (roll < 38) begin
        // element write anywhere in the store, not bound by the sizes
        case ($urandom_range(2))
          0:       op = mmg_pkg::OP_WRITE_A;
          1:       op = mmg_pkg::OP_WRITE_B;
          default: op = mmg_pkg::OP_WRITE_G;
        endcase
        add_beat(op, DIM_W'($urandom), DIM_W'($urandom), rand_elem(), gap);
      end else begin
        case ($urandom_range(2))
          0: begin
            op = mmg_pkg::OP_FORWARD;
            rl = lim_m;
            cl = lim_n;
            len = lim_k;
          end
          1: begin
            op = mmg_pkg::OP_GRAD_A;
            rl = lim_m;
            cl = lim_k;
            len = lim_n;
          end
          default: begin
            op = mmg_pkg::OP_GRAD_B;
            rl = lim_k;
            cl = lim_n;
            len = lim_m;
          end
        endcase
        row = pick_index(rl);
        col = pick_index(cl);
        // load every operand the walk will read before the compute beat
        if (row < rl && col < cl) begin
          for (t = 0; t < len; t++) begin
            case (op)
              mmg_pkg::OP_FORWARD: begin
                touch(mmg_pkg::OP_WRITE_A, row, t, gap);
                touch(mmg_pkg::OP_WRITE_B, t, col, gap);
              end
              mmg_pkg::OP_GRAD_A: begin
                touch(mmg_pkg::OP_WRITE_G, row, t, gap);
                touch(mmg_pkg::OP_WRITE_B, col, t, gap);
              end
              default: begin
                touch(mmg_pkg::OP_WRITE_A, t, row, gap);
                touch(mmg_pkg::OP_WRITE_G, t, col, gap);
              end
            endcase
          end
        end
        // element value of a compute beat is random and must not matter
        add_beat(op, row, col, DATA_W'($urandom), gap);
      end
    end
  endtask

  // driver: holds start until the beat is taken, idles at random
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        // beat taken: update the store copy or predict the result
        case (on_port.op)
          mmg_pkg::OP_WRITE_A: a_copy[{on_port.row, on_port.col}] = on_port.value;
          mmg_pkg::OP_WRITE_B: b_copy[{on_port.row, on_port.col}] = on_port.value;
          mmg_pkg::OP_WRITE_G: g_copy[{on_port.row, on_port.col}] = on_port.value;
          mmg_pkg::OP_FORWARD, mmg_pkg::OP_GRAD_A, mmg_pkg::OP_GRAD_B: begin
            expected_elems.push_back(inner_product(on_port));
          end
          default: ;
        endcase
      end
      if (!start || !busy) begin
        if (pending_beats.size() != 0 &&
            !(pending_beats[0].may_gap && $urandom_range(99) < GAP_PCT)) begin
          on_port = pending_beats.pop_front();
          start           <= 1'b1;
          op_i            <= on_port.op;
          row_index_i     <= on_port.row;
          col_index_i     <= on_port.col;
          element_value_i <= on_port.value;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: every result pulse must match the oldest prediction
  always @(posedge clk_i) begin : result_check
    elem_result_t want;
    if (rst_ni && result_valid_o) begin
      if (expected_elems.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= SHOW_MAX)
          $display("%0t: result with no compute pending: value %0d status %0d",
                   $time, result_value_o, status_o);
      end else begin
        want = expected_elems.pop_front();
        if (result_value_o !== want.value || status_o !== want.status) begin
          mismatch_cnt++;
          if (mismatch_cnt <= SHOW_MAX)
            $display("%0t: value exp %0d got %0d, status exp %0d got %0d", $time,
                     want.value, result_value_o, want.status, status_o);
        end
      end
    end
  end

  // watchdog: cycles with no beat, no result and no register write
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_valid_o || cfg_we_i) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("stalled for %0d cycles", stall_cycles);
      $display("** matrix_multiply_with_gradients: FAILED **");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int p;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed part on 1x1 matrices
    set_sizes(1, 1, 1);
    add_beat(mmg_pkg::OP_WRITE_A, '0, '0, DATA_W'(SAT_HI), 1'b1);
    add_beat(mmg_pkg::OP_WRITE_B, '0, '0, DATA_W'(SAT_HI), 1'b1);
    add_beat(mmg_pkg::OP_WRITE_G, '0, '0, DATA_W'(SAT_LO), 1'b1);
    add_beat(mmg_pkg::OP_FORWARD, '0, '0, '0, 1'b1);   // saturates high
    add_beat(mmg_pkg::OP_GRAD_A, '0, '0, '1, 1'b1);    // saturates low
    add_beat(mmg_pkg::OP_GRAD_B, '0, '0, '0, 1'b1);    // saturates low
    // index outside the sizes, one per compute op
    add_beat(mmg_pkg::OP_FORWARD, DIM_W'(1), '0, '0, 1'b1);
    add_beat(mmg_pkg::OP_GRAD_A, '0, '1, '0, 1'b1);
    add_beat(mmg_pkg::OP_GRAD_B, '1, '1, '1, 1'b1);
    // rounding: +half lsb rounds up, -half lsb rounds to zero
    add_beat(mmg_pkg::OP_WRITE_A, '0, '0, DATA_W'(1), 1'b1);
    add_beat(mmg_pkg::OP_WRITE_B, '0, '0, DATA_W'(ONE_Q / 2), 1'b1);
    add_beat(mmg_pkg::OP_FORWARD, '0, '0, '0, 1'b1);
    add_beat(mmg_pkg::OP_WRITE_A, '0, '0, '1, 1'b1);
    add_beat(mmg_pkg::OP_FORWARD, '0, '0, '0, 1'b1);
    // plain in-range product, no saturation
    add_beat(mmg_pkg::OP_WRITE_A, '0, '0, DATA_W'(ONE_Q), 1'b1);
    add_beat(mmg_pkg::OP_WRITE_G, '0, '0, DATA_W'(-ONE_Q), 1'b1);
    add_beat(mmg_pkg::OP_GRAD_B, '0, '0, '0, 1'b1);
    // dropped op codes
    add_beat(OP_RSVD_LO, '1, '1, '1, 1'b1);
    add_beat(OP_RSVD_HI, '0, '1, DATA_W'(SAT_LO), 1'b1);
    // writes at the far corner, outside the sizes
    add_beat(mmg_pkg::OP_WRITE_A, '1, '1, DATA_W'(SAT_LO), 1'b1);
    add_beat(mmg_pkg::OP_WRITE_B, '1, '1, DATA_W'(SAT_HI), 1'b1);
    add_beat(mmg_pkg::OP_WRITE_G, '1, '1, '1, 1'b1);

    // random part: fixed size settings, one without sender gaps, then random ones
    for (p = 0; p < N_FIXED; p++)
      random_phase(fixed_dims[p][0], fixed_dims[p][1], fixed_dims[p][2], p != CALM_PHASE);
    for (p = 0; p < N_RANDOM; p++)
      random_phase($urandom_range(SMALL_DIM / 2, 1), $urandom_range(SMALL_DIM / 2, 1),
                   $urandom_range(SMALL_DIM / 2, 1), 1'b1);

    // drain, then allow for the longest walk
    wait_idle();
    repeat (2 * MAX_DIM) @(posedge clk_i);
    if (mismatch_cnt == 0 && expected_elems.size() == 0) begin
      $display("** matrix_multiply_with_gradients: PASSED **");
    end else begin
      $display("** matrix_multiply_with_gradients: FAILED **");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/mmg_pkg.sv
sv/mmg_ctrl.sv
sv/mmg_datapath.sv
sv/matrix_multiply_with_gradients.sv
tb/matrix_multiply_with_gradients_tb.sv
